>>> src/bpa_pkg.sv
// Shared constants for the bitmap page allocator.
`timescale 1ns / 1ps
package bpa_pkg;
	localparam int NUM_PAGES   = 65536;
	localparam int STACK_DEPTH = 32;

	localparam int WORDS = NUM_PAGES / 32;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int XW    = ($clog2(NUM_PAGES) + 1 > 17) ? $clog2(NUM_PAGES) + 1 : 17;
	localparam int SCW   = $clog2(STACK_DEPTH + 1);
	localparam int SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam logic [28:0] BASE_ADDR     = 29'h0100000;
	localparam logic [28:0] CAP_ADDR      = 29'h10000000;
	localparam logic [28:0] FALLBACK_ADDR = 29'h1000000;
	localparam logic [28:0] DMA_START     = 29'h0200000;
	localparam logic [28:0] PG            = 29'd4096;
	localparam logic [47:0] DMA_LIMIT     = 48'h100000 + 48'(NUM_PAGES) * 48'd4096;
	localparam logic [XW-1:0] FALLBACK_PAGES = XW'((FALLBACK_ADDR - BASE_ADDR) >> 12);

	localparam logic [2:0] CMD_BEGIN  = 3'd0;
	localparam logic [2:0] CMD_ADD    = 3'd1;
	localparam logic [2:0] CMD_FINISH = 3'd2;
	localparam logic [2:0] CMD_ALLOC  = 3'd3;
	localparam logic [2:0] CMD_FREE   = 3'd4;
	localparam logic [2:0] CMD_DMAFREE = 3'd5;
	localparam logic [2:0] CMD_RUN    = 3'd6;
	localparam logic [2:0] CMD_QUERY  = 3'd7;
endpackage

>>> src/bpa_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module bpa_ram #(
	parameter int DW    = 32,
	parameter int AW    = 5,
	parameter int DEPTH = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/bitmap_page_allocator_unit.sv
// Top level of the bitmap page allocator: command sequencer over the used map and page stack.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | cmd, region_base, region_length, page_address,
//          |           |                       | run_length, dma_region
//  out     | output    | out_valid / out_stall | granted_address, granted, top_bytes
//
// One item at a time. Query and free go straight to the result; alloc from the stack first reads
// the stack RAM. Map updates read, modify and write each 32-page map word in turn; scans load
// each new map word into a buffer and then test its pages. Begin init and reset sweep all
// NUM_PAGES/32 map words (2048), one per cycle; no item is accepted during the sweep after reset.
// A result waits in the output register while out_stall is high; the next item is taken meanwhile.
`timescale 1ns / 1ps
module bitmap_page_allocator_unit
	import bpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [47:0] region_base,
	input  logic [47:0] region_length,
	input  logic [47:0] page_address,
	input  logic [16:0] run_length,
	input  logic        dma_region,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [47:0] granted_address,
	output logic        granted,
	output logic [28:0] top_bytes
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SWEEP  = 4'd1;
	localparam logic [3:0] S_RSTART = 4'd2;
	localparam logic [3:0] S_RRD    = 4'd3;
	localparam logic [3:0] S_RWR    = 4'd4;
	localparam logic [3:0] S_SCAN   = 4'd5;
	localparam logic [3:0] S_SCANW  = 4'd6;
	localparam logic [3:0] S_POP    = 4'd7;
	localparam logic [3:0] S_POPW   = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0]    state_q;
	logic          sweep_res_q;
	logic [WW-1:0] w_q;
	logic [XW-1:0] plo_q, phi_q, plast_q;
	logic          set_q;
	logic [28:0]   bump_q, top_q, hre_q, a_q;
	logic          run_mode_q;
	logic [16:0]   run_q, count_q;
	logic [SCW-1:0] cnt_q;
	logic [31:0]   buf_q;
	logic [WW-1:0] buf_addr_q;
	logic          buf_vld_q;
	logic [47:0]   res_addr_q;
	logic          res_ok_q;
	logic          out_vld_q;
	logic [47:0]   out_addr_q;
	logic          out_ok_q;
	logic [28:0]   out_top_q;

	logic          map_we;
	logic [WW-1:0] map_waddr, map_raddr;
	logic [31:0]   map_wdata, map_rdata;
	logic          stk_we;
	logic [47:0]   stk_rdata;

	logic          accept;
	logic [28:0]   scan_addr;
	logic [16:0]   scan_pg;
	logic [XW-1:0] idx;
	logic          beyond;
	logic [WW-1:0] cur_word;
	logic          page_bit;
	logic          scan_stop;
	logic [29:0]   a_next;
	logic [47:0]   lo48;
	logic [48:0]   hi49;
	logic [28:0]   lo29, hi29;
	logic          add_ok;
	logic [XW-1:0] add_plo, add_phi, pc, run_first;
	logic [4:0]    lo_b, hi_b;
	logic [31:0]   wmask;
	logic [31:0]   bitsel;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign scan_addr = run_mode_q ? a_q : bump_q;
	assign scan_pg   = scan_addr[28:12] - 17'd256;
	assign idx       = XW'(scan_pg);
	assign beyond    = (idx >= XW'(NUM_PAGES));
	assign cur_word  = idx[WW+4:5];
	assign bitsel    = 32'd1 << idx[4:0];
	assign page_bit  = beyond ? 1'b1 : ((buf_q & bitsel) != 32'd0);
	assign a_next    = {1'b0, a_q} + {1'b0, PG};
	assign scan_stop = run_mode_q ? (a_next > {1'b0, top_q}) : (bump_q >= top_q);

	assign lo48    = (region_base < 48'(BASE_ADDR)) ? 48'(BASE_ADDR) : region_base;
	assign hi49    = {1'b0, region_base} + {1'b0, region_length};
	assign hi29    = (hi49 > 49'(CAP_ADDR)) ? CAP_ADDR : hi49[28:0];
	assign add_ok  = (lo48 < 48'(hi29));
	assign lo29    = lo48[28:0];
	assign add_plo = XW'((lo29 - BASE_ADDR + 29'd4095) >> 12);
	assign add_phi = XW'((hi29 - BASE_ADDR) >> 12);
	assign pc      = (phi_q > XW'(NUM_PAGES)) ? XW'(NUM_PAGES) : phi_q;
	assign run_first = idx - XW'(count_q - 17'd1);

	assign lo_b  = (w_q == plo_q[WW+4:5]) ? plo_q[4:0] : 5'd0;
	assign hi_b  = (w_q == plast_q[WW+4:5]) ? plast_q[4:0] : 5'd31;
	assign wmask = (32'hFFFF_FFFF << lo_b) & (32'hFFFF_FFFF >> (5'd31 - hi_b));

	always_comb begin
		map_we    = 1'b0;
		map_waddr = w_q;
		map_wdata = 32'hFFFF_FFFF;
		map_raddr = (state_q == S_RRD) ? w_q : cur_word;
		case (state_q)
			S_SWEEP: begin
				map_we = 1'b1;
			end
			S_RWR: begin
				map_we    = 1'b1;
				map_wdata = set_q ? (map_rdata | wmask) : (map_rdata & ~wmask);
			end
			S_SCAN: begin
				if (!run_mode_q && !scan_stop && !beyond && buf_vld_q &&
				    buf_addr_q == cur_word && !page_bit) begin
					map_we    = 1'b1;
					map_waddr = cur_word;
					map_wdata = buf_q | bitsel;
				end
			end
			default: begin
			end
		endcase
	end

	assign stk_we = accept && cmd == CMD_FREE && page_address != 48'd0 &&
	                cnt_q < SCW'(STACK_DEPTH);

	bpa_ram #(.DW(32), .AW(WW), .DEPTH(WORDS)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	bpa_ram #(.DW(48), .AW(SAW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (cnt_q[SAW-1:0]),
		.wdata (page_address),
		.raddr (cnt_q[SAW-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_res_q <= 1'b0;
			w_q         <= '0;
			bump_q      <= BASE_ADDR;
			top_q       <= FALLBACK_ADDR;
			hre_q       <= '0;
			cnt_q       <= '0;
			buf_vld_q   <= 1'b0;
			out_vld_q   <= 1'b0;
			run_mode_q  <= 1'b0;
			set_q       <= 1'b0;
		end else begin
			if (out_vld_q && !out_stall && state_q != S_FIN) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_addr_q <= '0;
						res_ok_q   <= 1'b0;
						state_q    <= S_FIN;
						case (cmd)
							CMD_BEGIN: begin
								bump_q      <= BASE_ADDR;
								top_q       <= FALLBACK_ADDR;
								hre_q       <= '0;
								w_q         <= '0;
								buf_vld_q   <= 1'b0;
								sweep_res_q <= 1'b1;
								state_q     <= S_SWEEP;
							end
							CMD_ADD: begin
								if (add_ok) begin
									if (hi29 > hre_q) begin
										hre_q <= hi29;
									end
									plo_q   <= add_plo;
									phi_q   <= add_phi;
									set_q   <= 1'b0;
									state_q <= S_RSTART;
								end
							end
							CMD_FINISH: begin
								if (hre_q <= BASE_ADDR) begin
									top_q   <= FALLBACK_ADDR;
									plo_q   <= '0;
									phi_q   <= FALLBACK_PAGES;
									set_q   <= 1'b0;
									state_q <= S_RSTART;
								end else begin
									top_q <= hre_q;
								end
							end
							CMD_ALLOC: begin
								if (cnt_q != '0) begin
									cnt_q   <= cnt_q - SCW'(1);
									state_q <= S_POP;
								end else begin
									run_mode_q <= 1'b0;
									state_q    <= S_SCAN;
								end
							end
							CMD_FREE: begin
								if (stk_we) begin
									cnt_q <= cnt_q + SCW'(1);
								end
							end
							CMD_DMAFREE: begin
								if (page_address >= 48'(BASE_ADDR) && page_address < DMA_LIMIT) begin
									plo_q   <= XW'((page_address - 48'(BASE_ADDR)) >> 12);
									phi_q   <= XW'((page_address - 48'(BASE_ADDR)) >> 12) + XW'(1);
									set_q   <= 1'b0;
									state_q <= S_RSTART;
								end
							end
							CMD_RUN: begin
								if (run_length != 17'd0) begin
									run_mode_q <= 1'b1;
									a_q        <= dma_region ? DMA_START : BASE_ADDR;
									run_q      <= '0;
									count_q    <= run_length;
									state_q    <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SWEEP: begin
					w_q <= w_q + WW'(1);
					if (w_q == WW'(WORDS - 1)) begin
						state_q <= sweep_res_q ? S_FIN : S_IDLE;
					end
				end
				S_RSTART: begin
					buf_vld_q <= 1'b0;
					if (plo_q >= pc) begin
						state_q <= S_FIN;
					end else begin
						plast_q <= pc - XW'(1);
						w_q     <= plo_q[WW+4:5];
						state_q <= S_RRD;
					end
				end
				S_RRD: begin
					state_q <= S_RWR;
				end
				S_RWR: begin
					if (w_q == plast_q[WW+4:5]) begin
						state_q <= S_FIN;
					end else begin
						w_q     <= w_q + WW'(1);
						state_q <= S_RRD;
					end
				end
				S_SCAN: begin
					if (scan_stop) begin
						state_q <= S_FIN;
					end else if (!beyond && !(buf_vld_q && buf_addr_q == cur_word)) begin
						state_q <= S_SCANW;
					end else if (!run_mode_q) begin
						bump_q <= bump_q + PG;
						if (!page_bit) begin
							buf_q      <= buf_q | bitsel;
							res_addr_q <= 48'(bump_q);
							res_ok_q   <= 1'b1;
							state_q    <= S_FIN;
						end
					end else begin
						a_q <= a_next[28:0];
						if (page_bit) begin
							run_q <= '0;
						end else begin
							run_q <= run_q + 17'd1;
							if (run_q + 17'd1 == count_q) begin
								plo_q      <= run_first;
								phi_q      <= idx + XW'(1);
								set_q      <= 1'b1;
								res_addr_q <= 48'(BASE_ADDR) + (48'(run_first) << 12);
								res_ok_q   <= 1'b1;
								state_q    <= S_RSTART;
							end
						end
					end
				end
				S_SCANW: begin
					buf_q      <= map_rdata;
					buf_addr_q <= cur_word;
					buf_vld_q  <= 1'b1;
					state_q    <= S_SCAN;
				end
				S_POP: begin
					state_q <= S_POPW;
				end
				S_POPW: begin
					res_addr_q <= stk_rdata;
					res_ok_q   <= 1'b1;
					state_q    <= S_FIN;
				end
				S_FIN: begin
					if (!out_vld_q || !out_stall) begin
						out_vld_q   <= 1'b1;
						out_addr_q  <= res_addr_q;
						out_ok_q    <= res_ok_q;
						out_top_q   <= top_q;
						sweep_res_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_vld_q;
	assign granted_address = out_addr_q;
	assign granted         = out_ok_q;
	assign top_bytes       = out_top_q;
endmodule
